/* hdl/lis_pkg.sv */
// Shared types and constants for the longest increasing subsequence block.
// No dependencies.
`default_nettype none

package lis_pkg;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned LEN_W       = 11;
  localparam int unsigned MAX_LEN_DEF = 1024;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } in_t;

  typedef struct packed {
    logic [LEN_W-1:0] length;
    logic             overflow;
    logic             done_res;
  } out_t;

endpackage

`default_nettype wire

/* hdl/lis_tail_mem.sv */
// Tail table storage: single port, one access per cycle, registered read data.
// Depends on lis_pkg for the value width.
`default_nettype none

module lis_tail_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic                                clk,
  input  wire logic [AW-1:0]                       addr,
  input  wire logic                                we,
  input  wire logic                                re,
  input  wire logic signed [lis_pkg::VALUE_W-1:0]  wdata,
  output logic signed [lis_pkg::VALUE_W-1:0]       rdata
);
  import lis_pkg::*;

  logic signed [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

/* hdl/lis_ctrl.sv */
// Sequencer for the tail table: last-tail check, binary search with one shared
// comparator, table update and the result register. Depends on lis_pkg.
`default_nettype none

module lis_ctrl #(
  parameter int unsigned MAX_LEN = 1024,
  parameter int unsigned AW      = 10,
  parameter int unsigned CW      = 11
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire lis_pkg::in_t                        in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output lis_pkg::out_t                            out_data,
  output logic [AW-1:0]                            mem_addr,
  output logic                                     mem_we,
  output logic                                     mem_re,
  output logic signed [lis_pkg::VALUE_W-1:0]       mem_wdata,
  input  wire logic signed [lis_pkg::VALUE_W-1:0]  mem_rdata
);
  import lis_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LAST  = 6'b000010,
    S_PROBE = 6'b000100,
    S_CMP   = 6'b001000,
    S_WRITE = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t                    state_r, state_nxt;
  logic signed [VALUE_W-1:0] key_r, key_nxt;
  logic                      last_r, last_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic                      ovf_r, ovf_nxt;
  logic [AW-1:0]             lo_r, lo_nxt;
  logic [AW-1:0]             hi_r, hi_nxt;
  logic [AW-1:0]             mid_r, mid_nxt;
  logic [AW-1:0]             wr_addr_r, wr_addr_nxt;
  logic                      append_r, append_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_t                      out_data_r, out_data_nxt;

  logic          tail_less;   // shared comparator: stored tail < key
  logic [AW-1:0] probe_lo, probe_hi;
  logic          out_load;

  assign tail_less = mem_rdata < key_r;
  assign probe_lo  = tail_less ? mid_r + AW'(1) : lo_r;
  assign probe_hi  = tail_less ? hi_r : mid_r;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    last_nxt      = last_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    wr_addr_nxt   = wr_addr_r;
    append_nxt    = append_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_addr      = wr_addr_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_wdata     = key_r;

    case (state_r)
      S_IDLE: begin
        mem_addr = AW'(count_r - CW'(1));
        if (in_valid) begin
          key_nxt  = in_data.value;
          last_nxt = in_data.last;
          if (count_r == '0) begin
            append_nxt  = 1'b1;
            wr_addr_nxt = '0;
            state_nxt   = S_WRITE;
          end else begin
            mem_re     = 1'b1;
            append_nxt = 1'b0;
            state_nxt  = S_LAST;
          end
        end
      end
      S_LAST: begin
        if (tail_less) begin
          if (count_r != CW'(MAX_LEN)) begin
            append_nxt  = 1'b1;
            wr_addr_nxt = AW'(count_r);
            state_nxt   = S_WRITE;
          end else begin
            ovf_nxt   = 1'b1;
            state_nxt = S_DONE;
          end
        end else begin
          // last tail is already >= key, so the answer lies in [0, count-1]
          lo_nxt = '0;
          hi_nxt = AW'(count_r - CW'(1));
          if (count_r == CW'(1)) begin
            wr_addr_nxt = '0;
            state_nxt   = S_WRITE;
          end else begin
            state_nxt = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        mid_nxt   = lo_r + ((hi_r - lo_r) >> 1);
        mem_addr  = mid_nxt;
        mem_re    = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        lo_nxt = probe_lo;
        hi_nxt = probe_hi;
        if (probe_lo == probe_hi) begin
          wr_addr_nxt = probe_lo;
          state_nxt   = S_WRITE;
        end else begin
          state_nxt = S_PROBE;
        end
      end
      S_WRITE: begin
        mem_we = 1'b1;
        if (append_r) begin
          count_nxt = count_r + CW'(1);
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.length   = LEN_W'(count_r);
          out_data_nxt.overflow = ovf_r;
          out_data_nxt.done_res = last_r;
          if (last_r) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    last_r     <= last_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    wr_addr_r  <= wr_addr_nxt;
    append_r   <= append_nxt;
    out_data_r <= out_data_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_LEN))
    else $error("tail count above table depth");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> count_r == CW'(MAX_LEN))
    else $error("overflow flag set with table not full");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ({1'b0, mem_addr} <= (AW+1)'(count_r)) && (state_r == S_WRITE))
    else $error("tail write outside filled range");

  a_search_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE || state_r == S_CMP) |-> lo_r < hi_r)
    else $error("binary search window collapsed");

  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && last_r) |=> (count_r == '0) && !ovf_r)
    else $error("state not cleared after closing beat");

endmodule

`default_nettype wire

/* hdl/longest_increasing_subsequence.sv */
// Top level of the longest increasing subsequence block: control sequencer
// plus tail table memory. Depends on lis_pkg, lis_ctrl, lis_tail_mem.
//
//   channel  dir  ports                            beat contents
//   in       in   in_valid, in_ready, in_data      value (s32), last
//   out      out  out_valid, out_ready, out_data   length (11b), overflow, done_res
//
// An accepted beat goes through LAST, then binary search probes (up to ceil(log2(MAX_LEN)),
// 10 at the default depth), then WRITE and DONE; an append or a replace in a one-entry
// table skips the probes, the first beat of a sequence goes straight to WRITE, and a dropped
// append goes from LAST to DONE. Each probe is a PROBE and a CMP step because the single-port
// tail memory has a registered read. in_ready is high only in idle, which starts with the result.
// A finished result waits in the output register; a stalled out_ready holds the
// sequencer in its last step. Reset is synchronous; the table needs no clearing.
`default_nettype none

module longest_increasing_subsequence #(
  parameter int unsigned MAX_LEN = lis_pkg::MAX_LEN_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire lis_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output lis_pkg::out_t      out_data
);
  import lis_pkg::*;

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CW = $clog2(MAX_LEN + 1);

  logic [AW-1:0]             mem_addr;
  logic                      mem_we;
  logic                      mem_re;
  logic signed [VALUE_W-1:0] mem_wdata;
  logic signed [VALUE_W-1:0] mem_rdata;

  lis_ctrl #(
    .MAX_LEN (MAX_LEN),
    .AW      (AW),
    .CW      (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mem_addr  (mem_addr),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  lis_tail_mem #(
    .DEPTH (MAX_LEN),
    .AW    (AW)
  ) u_tail_mem (
    .clk   (clk),
    .addr  (mem_addr),
    .we    (mem_we),
    .re    (mem_re),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for longest_increasing_subsequence: directed table plus random
// sequences, checked against an in-bench patience-table predictor. Depends on lis_pkg and the DUT.

module tb_top;
  import lis_pkg::*;

  localparam int unsigned TB_MAX_LEN  = MAX_LEN_DEF;
  localparam int          QUIET_LIMIT = 4000;
  localparam int          HOLD_CYCLES = 500;
  localparam logic signed [VALUE_W-1:0] V_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] V_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
    logic                      typed;
    logic [LEN_W-1:0]          length;
    logic                      overflow;
  } dir_row_t;

  typedef struct packed {
    in_t  beat;
    logic typed;
    out_t want;
  } pending_t;

  // Expected result typed in only where obvious; other rows go through the predictor.
  localparam int N_DIR = 23;
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{V_MIN,         1'b1, 1'b1, 11'd1, 1'b0},  // single item sequences
    '{V_MAX,         1'b1, 1'b1, 11'd1, 1'b0},
    '{32'sd0,        1'b1, 1'b1, 11'd1, 1'b0},
    '{V_MAX,         1'b0, 1'b1, 11'd1, 1'b0},
    '{V_MAX,         1'b0, 1'b1, 11'd1, 1'b0},  // equal value does not grow
    '{V_MIN,         1'b0, 1'b1, 11'd1, 1'b0},  // replaces the only tail
    '{V_MAX,         1'b0, 1'b1, 11'd2, 1'b0},
    '{-32'sd1,       1'b0, 1'b0, 11'd0, 1'b0},
    '{32'sd0,        1'b0, 1'b0, 11'd0, 1'b0},
    '{32'sd0,        1'b1, 1'b0, 11'd0, 1'b0},
    '{32'sd5,        1'b0, 1'b0, 11'd0, 1'b0},  // strictly descending run
    '{32'sd4,        1'b0, 1'b0, 11'd0, 1'b0},
    '{32'sd3,        1'b0, 1'b0, 11'd0, 1'b0},
    '{32'sd2,        1'b0, 1'b0, 11'd0, 1'b0},
    '{32'sd1,        1'b1, 1'b0, 11'd0, 1'b0},
    '{32'sd10,       1'b0, 1'b0, 11'd0, 1'b0},
    '{32'sd9,        1'b0, 1'b0, 11'd0, 1'b0},
    '{32'sd2,        1'b0, 1'b0, 11'd0, 1'b0},
    '{32'sd5,        1'b0, 1'b0, 11'd0, 1'b0},
    '{32'sd3,        1'b0, 1'b0, 11'd0, 1'b0},
    '{32'sd7,        1'b0, 1'b0, 11'd0, 1'b0},
    '{32'sd101,      1'b0, 1'b0, 11'd0, 1'b0},
    '{32'sd18,       1'b1, 1'b0, 11'd0, 1'b0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  longest_increasing_subsequence #(.MAX_LEN(TB_MAX_LEN)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // predictor state: smallest tail per subsequence length
  logic signed [VALUE_W-1:0] tail_vals [TB_MAX_LEN];
  int unsigned tail_fill = 0;
  bit          seq_ovf = 1'b0;

  // queues fill at the front and drain from the back
  pending_t pending_q [$];
  out_t     expected_lis_q [$];
  pending_t cur_item;

  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  int error_cnt = 0;
  int items_accepted = 0;
  int results_checked = 0;
  int seqs_closed = 0;
  int ovf_results = 0;
  int peak_len = 0;

  function automatic out_t lis_advance(in_t beat);
    logic signed [VALUE_W-1:0] v;
    int unsigned lo, hi, mid;
    out_t res;
    v = beat.value;
    if (tail_fill == 0 || v > tail_vals[tail_fill-1]) begin
      if (tail_fill < TB_MAX_LEN) begin
        tail_vals[tail_fill] = v;
        tail_fill++;
      end else begin
        seq_ovf = 1'b1;
      end
    end else begin
      lo = 0;
      hi = tail_fill;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (tail_vals[mid] < v) lo = mid + 1;
        else hi = mid;
      end
      tail_vals[lo] = v;
    end
    res.length   = LEN_W'(tail_fill);
    res.overflow = seq_ovf;
    res.done_res = beat.last;
    if (beat.last) begin
      tail_fill = 0;
      seq_ovf = 1'b0;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_cnt++;
  endtask

  task automatic push_value(input int v, input bit l);
    pending_t p;
    p = '0;
    p.beat.value = v;
    p.beat.last  = l;
    pending_q.push_front(p);
  endtask

  task automatic queue_random(input int n_items);
    int added, seq_len, kind, v, i;
    added = 0;
    while (added < n_items) begin
      kind = $urandom_range(9);
      seq_len = $urandom_range(1, 30);
      v = int'($urandom());
      if (kind == 6) v = $urandom_range(1) ? V_MIN : V_MAX - 40;
      for (i = 0; i < seq_len; i++) begin
        case (kind)
          4, 5: v = int'($urandom_range(12)) - 6;          // narrow: many equal values
          6: v = v + int'($urandom_range(3));              // ascending near an extreme
          7: v = v - int'($urandom_range(1, 5000));
          8: v = (i % 7 == 6) ? v - int'($urandom_range(100000))
                              : v + int'($urandom_range(1, 50));
          default: v = int'($urandom());
        endcase
        // kind 9 is noise: close marks land anywhere
        push_value(v, (kind == 9) ? bit'($urandom_range(1)) : (i == seq_len - 1));
      end
      added += seq_len;
    end
  endtask

  task automatic wait_drain();
    while (pending_q.size() != 0 || in_valid || expected_lis_q.size() != 0)
      @(negedge clk);
  endtask

  // sender
  always @(posedge clk) begin
    out_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        res = lis_advance(cur_item.beat);
        if (cur_item.typed) res = cur_item.want;
        expected_lis_q.push_front(res);
        items_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          cur_item = pending_q.pop_back();
          in_data  <= cur_item.beat;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_lis_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending, length %0d",
                                    out_data.length));
        end else begin
          want = expected_lis_q.pop_back();
          if (out_data.length !== want.length)
            report_mismatch($sformatf("length %0d, want %0d", out_data.length, want.length));
          if (out_data.overflow !== want.overflow)
            report_mismatch($sformatf("overflow %b, want %b", out_data.overflow,
                                      want.overflow));
          if (out_data.done_res !== want.done_res)
            report_mismatch($sformatf("done_res %b, want %b", out_data.done_res,
                                      want.done_res));
          results_checked++;
          if (want.done_res) seqs_closed++;
          if (want.overflow) ovf_results++;
          if (int'(want.length) > peak_len) peak_len = int'(want.length);
        end
      end
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[%0t] watchdog: no beat moved for %0d cycles, %0d results outstanding",
                 $realtime, QUIET_LIMIT, expected_lis_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    pending_t p;
    int base;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    in_idle_pct  = 25;
    out_idle_pct = 65;
    for (int r = 0; r < N_DIR; r++) begin
      p = '0;
      p.beat.value   = DIR_ROWS[r].value;
      p.beat.last    = DIR_ROWS[r].last;
      p.typed        = DIR_ROWS[r].typed;
      p.want.length   = DIR_ROWS[r].length;
      p.want.overflow = DIR_ROWS[r].overflow;
      p.want.done_res = DIR_ROWS[r].last;
      pending_q.push_front(p);
    end
    queue_random(60);
    wait_drain();

    in_idle_pct  = 65;
    out_idle_pct = 25;
    queue_random(60);
    hold_req++;  // long receiver hold while items keep coming
    wait_drain();

    in_idle_pct  = 0;
    out_idle_pct = 0;
    // close any open sequence, fill the table past its depth, then replace within it
    push_value(0, 1'b1);
    base = V_MIN;
    for (int i = 0; i < TB_MAX_LEN + 2; i++) begin
      push_value(base, 1'b0);
      base += int'($urandom_range(1, 1000));
    end
    push_value(V_MIN + 1, 1'b0);
    push_value(V_MIN, 1'b1);
    queue_random(30);
    wait_drain();

    repeat (40) @(posedge clk);
    $display("run covered %0d items in %0d closed sequences, %0d results checked",
             items_accepted, seqs_closed, results_checked);
    $display("peak length %0d, %0d results carried the overflow flag",
             peak_len, ovf_results);
    if (error_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
